// ===== src/mowt_pkg.sv =====
// ----------------------------------------------------------------------------
// mowt_pkg: shared types and codes of the wait tracker
// Result kinds and the request record passed from front to back.
// ----------------------------------------------------------------------------
package mowt_pkg;

  localparam int unsigned CmdW   = 1;
  localparam int unsigned ProcW  = 4;
  localparam int unsigned ObjW   = 4;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CountW = 7;

  localparam logic [CmdW-1:0] CMD_WAIT   = 1'b0;
  localparam logic [CmdW-1:0] CMD_SIGNAL = 1'b1;

  localparam logic [KindW-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KindW-1:0] KIND_FULL    = 2'd1;
  localparam logic [KindW-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KindW-1:0] KIND_NONE    = 2'd3;

  // Request after the front has wrapped its indexes.
  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ProcW-1:0] proc;
    logic [ObjW-1:0]  obj;
  } req_t;

endpackage

// ===== src/mowt_front.sv =====
// ----------------------------------------------------------------------------
// mowt_front: request intake
// Wrap indexes into range and hold requests in a two-entry queue.
// ----------------------------------------------------------------------------
module mowt_front #(
  parameter int unsigned NUM_PROCS = 16,
  parameter int unsigned NUM_OBJS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [mowt_pkg::CmdW-1:0]      cmd_i,
  input  logic [mowt_pkg::ProcW-1:0]     proc_index_i,
  input  logic [mowt_pkg::ObjW-1:0]      obj_index_i,
  output logic                           req_valid_o,
  input  logic                           req_ready_i,
  output mowt_pkg::req_t                 req_o
);

  localparam int unsigned ProcW = mowt_pkg::ProcW;
  localparam int unsigned ObjW  = mowt_pkg::ObjW;

  mowt_pkg::req_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  mowt_pkg::req_t incoming;
  logic           push, pop;

  // Wrap indexes at or above the parameter; the wrapped value is a constant
  // per input code, so this is a small lookup table.
  always_comb begin
    incoming.cmd  = cmd_i;
    incoming.proc = proc_index_i;
    incoming.obj  = obj_index_i;
    for (int i = 0; i < 2**ProcW; i++) begin
      if (proc_index_i == ProcW'(i)) incoming.proc = ProcW'(i % NUM_PROCS);
    end
    for (int i = 0; i < 2**ObjW; i++) begin
      if (obj_index_i == ObjW'(i)) incoming.obj = ObjW'(i % NUM_OBJS);
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = buf_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = req_valid_o && req_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= incoming;
  end

endmodule

// ===== src/mowt_back.sv =====
// ----------------------------------------------------------------------------
// mowt_back: wait table engine
// Append waits, walk the table newest first on a signal, then compact it.
// ----------------------------------------------------------------------------
module mowt_back #(
  parameter int unsigned NUM_PROCS = 16,
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  mowt_pkg::req_t                req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mowt_pkg::KindW-1:0]    kind_o,
  output logic [mowt_pkg::ProcW-1:0]    proc_id_o,
  output logic [mowt_pkg::CountW-1:0]   waits_left_o,
  output logic                          woken_o,
  output logic                          last_o
);

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned FillW = $clog2(NUM_SLOTS + 1);
  localparam int unsigned PIdxW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned CntW  = mowt_pkg::CountW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN, ST_EMIT, ST_FLUSH, ST_COMP_RD, ST_COMP, ST_OUT
  } state_e;

  state_e state_q;

  // Slot table memory: one write port, one registered read port.
  logic [mowt_pkg::ProcW-1:0] mem_proc [NUM_SLOTS];
  logic [mowt_pkg::ObjW-1:0]  mem_obj  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]       rel_q;        // released marks for this signal
  logic [mowt_pkg::ProcW-1:0] rd_proc_q;
  logic [mowt_pkg::ObjW-1:0]  rd_obj_q;
  logic                       we;
  logic [SlotW-1:0]           waddr, raddr;
  logic [mowt_pkg::ProcW-1:0] wproc;
  logic [mowt_pkg::ObjW-1:0]  wobj;

  logic [CntW-1:0]  cnt_q [NUM_PROCS];
  logic [FillW-1:0] fill_q, rp_q, wp_q;
  mowt_pkg::req_t   cur_q;
  logic             any_q;
  logic             cnt_stale_q;

  // Newest release found so far; sent once the next one or the end is known.
  logic [mowt_pkg::ProcW-1:0]  hold_proc_q;
  logic [CntW-1:0]             hold_left_q;
  logic                        hold_woken_q;

  logic [mowt_pkg::KindW-1:0]  kind_q;
  logic [mowt_pkg::ProcW-1:0]  proc_q;
  logic [CntW-1:0]             left_q;
  logic                        woken_q, last_q, ov_q;

  logic [PIdxW-1:0] pidx_req, pidx_rd;
  logic [CntW-1:0]  dec;
  logic             more;
  logic             out_free, out_load;

  assign pidx_req = PIdxW'(cur_q.proc);
  assign pidx_rd  = PIdxW'(rd_proc_q);
  assign dec      = (cnt_q[pidx_rd] != '0) ? cnt_q[pidx_rd] - 1'b1 : '0;
  // Another older entry left to inspect after rp_q.
  assign more     = (rp_q != '0);

  assign out_free = !ov_q || out_ready_i;
  assign out_load = out_free && ((state_q == ST_EMIT && any_q) || state_q == ST_FLUSH
                                 || state_q == ST_OUT);

  assign req_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign proc_id_o    = proc_q;
  assign waits_left_o = left_q;
  assign woken_o      = woken_q;
  assign last_o       = last_q;

  always_comb begin
    we    = 1'b0;
    waddr = SlotW'(wp_q);
    wproc = rd_proc_q;
    wobj  = rd_obj_q;
    raddr = SlotW'(rp_q);
    if (state_q == ST_COMP && !rel_q[SlotW'(rp_q)]) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_proc[waddr] <= wproc;
      mem_obj[waddr]  <= wobj;
    end else if (state_q == ST_IDLE && req_valid_i && req_i.cmd == mowt_pkg::CMD_WAIT
                 && fill_q < FillW'(NUM_SLOTS)) begin
      mem_proc[SlotW'(fill_q)] <= req_i.proc;
      mem_obj[SlotW'(fill_q)]  <= req_i.obj;
    end
    rd_proc_q <= mem_proc[raddr];
    rd_obj_q  <= mem_obj[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      rp_q         <= '0;
      wp_q         <= '0;
      any_q        <= 1'b0;
      ov_q         <= 1'b0;
      rel_q        <= '0;
      cur_q        <= '0;
      hold_proc_q  <= '0;
      hold_left_q  <= '0;
      hold_woken_q <= 1'b0;
      kind_q       <= '0;
      proc_q       <= '0;
      left_q       <= '0;
      woken_q      <= 1'b0;
      last_q       <= 1'b0;
      for (int i = 0; i < NUM_PROCS; i++) cnt_q[i] <= '0;
    end else begin
      if (out_load) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (req_valid_i) begin
            cur_q <= req_i;
            if (req_i.cmd == mowt_pkg::CMD_WAIT) begin
              if (fill_q < FillW'(NUM_SLOTS)) begin
                fill_q <= fill_q + 1'b1;
                if (cnt_q[PIdxW'(req_i.proc)] != {CntW{1'b1}}) begin
                  cnt_q[PIdxW'(req_i.proc)] <= cnt_q[PIdxW'(req_i.proc)] + 1'b1;
                end
              end
              state_q <= ST_OUT;
            end else begin
              any_q <= 1'b0;
              rel_q <= '0;
              if (fill_q == '0) begin
                state_q <= ST_OUT;
              end else begin
                rp_q    <= fill_q - 1'b1;
                state_q <= ST_SCAN_RD;
              end
            end
          end
        end
        ST_SCAN_RD: state_q <= ST_SCAN;   // read data lands next cycle
        ST_SCAN: begin
          if (rd_obj_q == cur_q.obj) begin
            state_q <= ST_EMIT;
          end else if (more) begin
            rp_q    <= rp_q - 1'b1;
            state_q <= ST_SCAN_RD;
          end else if (any_q) begin
            state_q <= ST_FLUSH;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_EMIT: begin
          // Send the previous release first; hold until the result register is free.
          if (!any_q || out_free) begin
            if (any_q) begin
              kind_q  <= mowt_pkg::KIND_RELEASE;
              proc_q  <= hold_proc_q;
              left_q  <= hold_left_q;
              woken_q <= hold_woken_q;
              last_q  <= 1'b0;
            end
            rel_q[SlotW'(rp_q)] <= 1'b1;
            any_q           <= 1'b1;
            cnt_q[pidx_rd]  <= dec;
            hold_proc_q     <= mowt_pkg::ProcW'(pidx_rd);
            hold_left_q     <= dec;
            hold_woken_q    <= (cnt_q[pidx_rd] == CntW'(1));
            if (more) begin
              rp_q    <= rp_q - 1'b1;
              state_q <= ST_SCAN_RD;
            end else begin
              state_q <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          // The held release is the final result of this signal.
          if (out_free) begin
            kind_q  <= mowt_pkg::KIND_RELEASE;
            proc_q  <= hold_proc_q;
            left_q  <= hold_left_q;
            woken_q <= hold_woken_q;
            last_q  <= 1'b1;
            rp_q    <= '0;
            wp_q    <= '0;
            state_q <= ST_COMP_RD;
          end
        end
        ST_COMP_RD: state_q <= ST_COMP;
        ST_COMP: begin
          if (!rel_q[SlotW'(rp_q)]) wp_q <= wp_q + 1'b1;
          if (rp_q + 1'b1 == fill_q) begin
            fill_q  <= wp_q + FillW'(!rel_q[SlotW'(rp_q)]);
            state_q <= ST_IDLE;
          end else begin
            rp_q    <= rp_q + 1'b1;
            state_q <= ST_COMP_RD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            woken_q <= 1'b0;
            last_q  <= 1'b1;
            state_q <= ST_IDLE;
            if (cur_q.cmd == mowt_pkg::CMD_SIGNAL) begin
              kind_q <= mowt_pkg::KIND_NONE;
              proc_q <= '0;
              left_q <= '0;
            end else begin
              // fill_q and count already updated when accepted
              kind_q <= cnt_stale_q ? mowt_pkg::KIND_FULL : mowt_pkg::KIND_ACCEPT;
              proc_q <= cur_q.proc;
              left_q <= cnt_q[pidx_req];
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Remember whether the last request found the table full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_stale_q <= 1'b0;
    end else if (state_q == ST_IDLE && req_valid_i) begin
      cnt_stale_q <= (fill_q == FillW'(NUM_SLOTS));
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(NUM_SLOTS)) else $error("fill beyond table");
  a_load_ov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> ov_q)
    else $error("release result lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i) |=> (ov_q && $stable({kind_q, proc_q, left_q, woken_q, last_q})))
    else $error("result changed while waiting");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_ready_o && req_valid_i) |=> !req_ready_o) else $error("double intake");

endmodule

// ===== src/multi_object_wait_tracker.sv =====
// ----------------------------------------------------------------------------
// multi_object_wait_tracker: wait-entry table for waits on several objects
// Top level: request queue in front, table engine behind.
// ----------------------------------------------------------------------------
// A wait request appends one entry (process, object) and answers with the
// process's new wait count, or with a table-full result. A signal request
// walks the table newest first through one memory read port, sends the last
// release after the walk, then compacts the table. One request is worked at
// a time; a two-entry queue keeps accepting requests meanwhile. Results carry
// last on the final one.
module multi_object_wait_tracker #(
  parameter int unsigned NUM_PROCS = 16,
  parameter int unsigned NUM_OBJS  = 16,
  parameter int unsigned NUM_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mowt_pkg::CmdW-1:0]    cmd_i,
  input  logic [mowt_pkg::ProcW-1:0]   proc_index_i,
  input  logic [mowt_pkg::ObjW-1:0]    obj_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mowt_pkg::KindW-1:0]   kind_o,
  output logic [mowt_pkg::ProcW-1:0]   proc_id_o,
  output logic [mowt_pkg::CountW-1:0]  waits_left_o,
  output logic                         woken_o,
  output logic                         last_o
);

  mowt_pkg::req_t req;
  logic           req_valid, req_ready;

  // Accept and wrap requests.
  mowt_front #(.NUM_PROCS(NUM_PROCS), .NUM_OBJS(NUM_OBJS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .proc_index_i,
    .obj_index_i, .req_valid_o(req_valid), .req_ready_i(req_ready), .req_o(req)
  );

  // Execute against the table.
  mowt_back #(.NUM_PROCS(NUM_PROCS), .NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready),
    .req_i(req), .out_valid_o, .out_ready_i, .kind_o, .proc_id_o,
    .waits_left_o, .woken_o, .last_o
  );

endmodule

// ===== tb/tb_multi_object_wait_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_multi_object_wait_tracker: self-checking bench of the wait-entry table
// Drives wait and signal requests through the request channel, predicts every
// result with a local table model and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_multi_object_wait_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NProcs = 16;
  localparam int NObjs = 16;
  localparam int NSlots = 64;
  localparam int StallLimit = 20000;

  // One expected result of the block.
  typedef struct packed {
    logic [mowt_pkg::KindW-1:0]  kind;
    logic [mowt_pkg::ProcW-1:0]  proc_id;
    logic [mowt_pkg::CountW-1:0] waits_left;
    logic                        woken;
    logic                        last;
  } wait_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [mowt_pkg::CmdW-1:0] cmd_i = mowt_pkg::CMD_WAIT;
  logic [mowt_pkg::ProcW-1:0] proc_index_i = '0;
  logic [mowt_pkg::ObjW-1:0] obj_index_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [mowt_pkg::KindW-1:0] kind_o;
  logic [mowt_pkg::ProcW-1:0] proc_id_o;
  logic [mowt_pkg::CountW-1:0] waits_left_o;
  logic woken_o;
  logic last_o;

  // Predictor state: packed entry table in insertion order plus counts.
  logic [mowt_pkg::ProcW-1:0] entry_proc[$];
  logic [mowt_pkg::ObjW-1:0] entry_obj[$];
  logic [mowt_pkg::CountW-1:0] proc_waits[NProcs];
  wait_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  multi_object_wait_tracker dut (.*);

  // Advance the table model by one request and queue the results it causes.
  task automatic predict_request(input logic [mowt_pkg::CmdW-1:0] cmd,
                                 input logic [mowt_pkg::ProcW-1:0] p,
                                 input logic [mowt_pkg::ObjW-1:0] o);
    wait_result_t r;
    int released;
    logic [mowt_pkg::ProcW-1:0] wp;
    released = 0;
    if (cmd == mowt_pkg::CMD_WAIT) begin
      if (entry_proc.size() >= NSlots) begin
        r = '{mowt_pkg::KIND_FULL, p, proc_waits[p], 1'b0, 1'b1};
      end else begin
        entry_proc.push_back(p);
        entry_obj.push_back(o);
        if (proc_waits[p] < 127) proc_waits[p]++;
        r = '{mowt_pkg::KIND_ACCEPT, p, proc_waits[p], 1'b0, 1'b1};
      end
      pending_results.push_back(r);
      return;
    end
    // Walk newest first; deleting from the back keeps order of survivors.
    for (int i = entry_proc.size() - 1; i >= 0; i--) begin
      if (entry_obj[i] == o) begin
        wp = entry_proc[i];
        r = '{mowt_pkg::KIND_RELEASE, wp, '0, 1'b0, 1'b0};
        if (proc_waits[wp] > 0) begin
          proc_waits[wp]--;
          r.woken = (proc_waits[wp] == 0);
        end
        r.waits_left = proc_waits[wp];
        pending_results.push_back(r);
        entry_proc.delete(i);
        entry_obj.delete(i);
        released++;
      end
    end
    if (released == 0) begin
      r = '{mowt_pkg::KIND_NONE, '0, '0, 1'b0, 1'b1};
      pending_results.push_back(r);
    end else begin
      pending_results[$].last = 1'b1;
    end
  endtask

  // Send one request, honoring the sender idle rate; hold until accepted.
  task automatic send_request(input logic [mowt_pkg::CmdW-1:0] cmd,
                              input logic [mowt_pkg::ProcW-1:0] p,
                              input logic [mowt_pkg::ObjW-1:0] o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    proc_index_i <= p;
    obj_index_i <= o;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(cmd, p, o);
  endtask

  // Drop valid and wait until every expected result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Fill the table completely, hit the full case, then release every wait on 4'hF.
  task automatic test_full_table();
    for (int i = 0; i < NSlots; i++) send_request(mowt_pkg::CMD_WAIT, 4'(i), 4'hF);
    send_request(mowt_pkg::CMD_WAIT, 4'h0, 4'h3);
    send_request(mowt_pkg::CMD_WAIT, 4'hF, 4'h0);
    send_request(mowt_pkg::CMD_SIGNAL, 4'h0, 4'hF);
    drain();
  endtask

  // Extremes, duplicates, signal with no waiters, signal ignoring proc.
  task automatic test_directed();
    send_request(mowt_pkg::CMD_SIGNAL, 4'hF, 4'h0);
    send_request(mowt_pkg::CMD_WAIT, 4'h0, 4'h0);
    send_request(mowt_pkg::CMD_WAIT, 4'hF, 4'hF);
    send_request(mowt_pkg::CMD_WAIT, 4'h5, 4'hA);
    send_request(mowt_pkg::CMD_WAIT, 4'h5, 4'hA);
    send_request(mowt_pkg::CMD_WAIT, 4'h5, 4'h3);
    send_request(mowt_pkg::CMD_WAIT, 4'hA, 4'hA);
    send_request(mowt_pkg::CMD_SIGNAL, 4'hF, 4'hA);
    send_request(mowt_pkg::CMD_SIGNAL, 4'h0, 4'h3);
    send_request(mowt_pkg::CMD_SIGNAL, 4'h0, 4'h0);
    send_request(mowt_pkg::CMD_SIGNAL, 4'h0, 4'hF);
    send_request(mowt_pkg::CMD_SIGNAL, 4'h0, 4'hF);
    drain();
  endtask

  // Random mix; a few objects keep matches frequent, waits outnumber signals.
  task automatic test_random(input int n);
    logic [mowt_pkg::CmdW-1:0] c;
    for (int i = 0; i < n; i++) begin
      c = ($urandom_range(99) < 65) ? mowt_pkg::CMD_WAIT : mowt_pkg::CMD_SIGNAL;
      send_request(c, 4'($urandom), ($urandom_range(3) == 0) ? 4'($urandom_range(NObjs - 1))
                                                              : 4'($urandom_range(3)));
    end
    drain();
  endtask

  // Receiver: stall at the configured rate, check each accepted result.
  always @(posedge clk_i) begin
    wait_result_t exp_r;
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d proc=%0d left=%0d", $time, kind_o,
                 proc_id_o, waits_left_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r !== {kind_o, proc_id_o, waits_left_o, woken_o, last_o}) begin
          $display("%0t: mismatch expected kind=%0d proc=%0d left=%0d woken=%0b last=%0b",
                   $time, exp_r.kind, exp_r.proc_id, exp_r.waits_left, exp_r.woken,
                   exp_r.last);
          $display("%0t:          actual kind=%0d proc=%0d left=%0d woken=%0b last=%0b",
                   $time, kind_o, proc_id_o, waits_left_o, woken_o, last_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NProcs; i++) proc_waits[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 25;
    recv_idle_pct = 79;
    test_directed();
    test_full_table();
    test_random(60);
    send_idle_pct = 79;
    recv_idle_pct = 25;
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_table();
    test_random(46);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/mowt_pkg.sv
src/mowt_front.sv
src/mowt_back.sv
src/multi_object_wait_tracker.sv
tb/tb_multi_object_wait_tracker.sv
